// File: rtl/core/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PICP_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("picp: forbidden condition seen");
`define PICP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("picp: implication failed");
`else
`define PICP_ASSERT_NEVER(label, clk, rst_n, expr)
`define PICP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/picp_pkg.sv
// types and helpers shared by the point in polygon test
package picp_pkg;

	localparam int CoordW = 16;
	localparam int DiffW  = CoordW + 1;
	localparam int ProdW  = 2 * DiffW;
	localparam int CrossW = ProdW + 1;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic                    has_inner;
		logic                    last;
		logic                    ovf;
		logic signed [DiffW-1:0] ax;
		logic signed [DiffW-1:0] ay;
		logic signed [DiffW-1:0] bx;
		logic signed [DiffW-1:0] by;
		logic signed [DiffW-1:0] cx;
		logic signed [DiffW-1:0] cy;
		logic signed [DiffW-1:0] dx;
		logic signed [DiffW-1:0] dy;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	// exact difference of two coordinates
	function automatic logic signed [DiffW-1:0] diff17(
		input logic signed [CoordW-1:0] a,
		input logic signed [CoordW-1:0] b
	);
		diff17 = {a[CoordW-1], a} - {b[CoordW-1], b};
	endfunction

endpackage

// File: rtl/core/picp_front.sv
// front part: tracks vertices and forms the edge operands of each item
module picp_front #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic signed [15:0]    point_x,
	input  logic signed [15:0]    point_y,
	input  logic signed [15:0]    vertex_x,
	input  logic signed [15:0]    vertex_y,
	input  logic                  last_vertex,
	output logic                  push,
	output picp_pkg::entry_t      entry
);

	localparam int CntW = $clog2(MAX_VERTICES + 1);
	localparam logic [CntW-1:0] MaxC = CntW'(MAX_VERTICES);

	logic [CntW-1:0]    edge_cnt_q;
	logic               too_many_q;
	logic signed [15:0] first_x_q, first_y_q, prev_x_q, prev_y_q;

	logic               room;
	logic               is_first;
	logic signed [15:0] prev_nx, prev_ny, first_nx, first_ny;

	// vertex bookkeeping for this item
	always_comb begin
		room     = edge_cnt_q < MaxC;
		is_first = edge_cnt_q == '0;
		prev_nx  = room ? vertex_x : prev_x_q;
		prev_ny  = room ? vertex_y : prev_y_q;
		first_nx = (room && is_first) ? vertex_x : first_x_q;
		first_ny = (room && is_first) ? vertex_y : first_y_q;
	end

	// work entry: inner edge prev->vertex, closing edge prev->first
	always_comb begin
		entry.has_inner = room && !is_first;
		entry.last      = last_vertex;
		entry.ovf       = too_many_q || !room;
		entry.ax        = picp_pkg::diff17(vertex_x, prev_x_q);
		entry.ay        = picp_pkg::diff17(vertex_y, prev_y_q);
		entry.bx        = picp_pkg::diff17(point_x, prev_x_q);
		entry.by        = picp_pkg::diff17(point_y, prev_y_q);
		entry.cx        = picp_pkg::diff17(first_nx, prev_nx);
		entry.cy        = picp_pkg::diff17(first_ny, prev_ny);
		entry.dx        = picp_pkg::diff17(point_x, prev_nx);
		entry.dy        = picp_pkg::diff17(point_y, prev_ny);
		push            = accept && (entry.has_inner || last_vertex);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			too_many_q <= 1'b0;
		end else if (accept) begin
			if (last_vertex) begin
				edge_cnt_q <= '0;
				too_many_q <= 1'b0;
			end else if (room) begin
				edge_cnt_q <= edge_cnt_q + CntW'(1);
			end else begin
				too_many_q <= 1'b1;
			end
		end
	end

	// stored vertices
	always_ff @(posedge clk) begin
		if (accept) begin
			first_x_q <= first_nx;
			first_y_q <= first_ny;
			prev_x_q  <= prev_nx;
			prev_y_q  <= prev_ny;
		end
	end

endmodule

// File: rtl/core/picp_fifo.sv
// two entry queue between front and back
module picp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  picp_pkg::entry_t wdata,
	input  logic             pop,
	output picp_pkg::entry_t rdata,
	output logic             full,
	output logic             empty
);

	picp_pkg::entry_t mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: rtl/core/picp_back.sv
// back part: cross products, sign count and result register
module picp_back #(
	parameter int MAX_VERTICES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  picp_pkg::entry_t head,
	input  logic             head_valid,
	output logic             pop,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             inside_res,
	output logic             overflow
);

	localparam int CntW = $clog2(MAX_VERTICES + 1);

	logic                              valid_s1;
	logic                              has_inner_s1, last_s1, ovf_s1;
	logic signed [picp_pkg::ProdW-1:0] p0_s1, p1_s1, p2_s1, p3_s1;

	logic [CntW-1:0] neg_q, inner_q;
	logic            out_valid_q, inside_q, ovf_q;

	logic                               out_free, take_s1, load_s1;
	logic signed [picp_pkg::CrossW-1:0] z_in, z_cl;
	logic                               neg_in, neg_cl;
	logic [CntW-1:0]                    neg_nx, inner_nx;

	// handshake between stages
	always_comb begin
		out_free = !out_valid_q || out_ready;
		take_s1  = valid_s1 && (!last_s1 || out_free);
		load_s1  = head_valid && (!valid_s1 || take_s1);
		pop      = load_s1;
	end

	// stage 1: four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || take_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			has_inner_s1 <= head.has_inner;
			last_s1      <= head.last;
			ovf_s1       <= head.ovf;
			p0_s1        <= head.ax * head.by;
			p1_s1        <= head.ay * head.bx;
			p2_s1        <= head.cx * head.dy;
			p3_s1        <= head.cy * head.dx;
		end
	end

	// stage 2: signs and running counts
	always_comb begin
		z_in     = {p0_s1[picp_pkg::ProdW-1], p0_s1} - {p1_s1[picp_pkg::ProdW-1], p1_s1};
		z_cl     = {p2_s1[picp_pkg::ProdW-1], p2_s1} - {p3_s1[picp_pkg::ProdW-1], p3_s1};
		neg_in   = has_inner_s1 && z_in[picp_pkg::CrossW-1];
		neg_cl   = last_s1 && z_cl[picp_pkg::CrossW-1];
		neg_nx   = neg_q + CntW'(neg_in) + CntW'(neg_cl);
		inner_nx = inner_q + CntW'(has_inner_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= '0;
			inner_q <= '0;
		end else if (take_s1) begin
			neg_q   <= last_s1 ? '0 : neg_nx;
			inner_q <= last_s1 ? '0 : inner_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			ovf_q    <= ovf_s1;
			inside_q <= !ovf_s1 && (neg_nx == '0 || neg_nx == inner_nx + CntW'(1));
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;
	assign overflow   = ovf_q;

endmodule

// File: rtl/core/point_in_convex_polygon.sv
// top level of the streaming point in convex polygon test
//
// Usage: send the polygon's vertices in order, one item per vertex, each
// carrying the query point; mark the final vertex with last_vertex. Input and
// output use valid/ready; an item moves when both are high.
// One result item (inside_res, overflow) follows each polygon's last vertex.
// Vertices beyond MAX_VERTICES are dropped and the result shows overflow = 1
// with inside_res = 0.
// Throughput: one vertex per cycle while in_ready is high, set by the
// front's single vertex register update; the back works one queue entry per
// cycle with four 17x17 multiplies unless a last entry waits on out_ready.
// A result passes the queue write, the product stage and the result register.
// Stall: while out_ready is low the result holds; the two entry queue fills
// and in_ready drops once it is full.
// Reset: arst_n clears all counts, the queue and the result valid flag; the
// block takes items from the first clock edge after reset is released.
`include "assert_macros.svh"

module point_in_convex_polygon #(
	parameter int MAX_VERTICES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               inside_res,
	output logic               overflow
);

	logic             accept, push, pop, full, empty;
	picp_pkg::entry_t wr_entry, head;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// vertex tracking
	picp_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.point_x    (point_x),
		.point_y    (point_y),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.last_vertex(last_vertex),
		.push       (push),
		.entry      (wr_entry)
	);

	// decoupling queue
	picp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wr_entry),
		.pop   (pop),
		.rdata (head),
		.full  (full),
		.empty (empty)
	);

	// arithmetic and result
	picp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!empty),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.inside_res(inside_res),
		.overflow  (overflow)
	);

	// checks
	`PICP_ASSERT_NEVER(a_push_full, clk, arst_n, push && full)
	`PICP_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`PICP_ASSERT_IMPLY(a_ovf_outside, clk, arst_n, out_valid && overflow, !inside_res)

endmodule

// File: tb/point_in_convex_polygon_checker.sv
`timescale 1ns / 1ps
// checker that predicts and compares each polygon verdict of the point in polygon block
module point_in_convex_polygon_checker #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [picp_pkg::CoordW-1:0] point_x,
	input  logic signed [picp_pkg::CoordW-1:0] point_y,
	input  logic signed [picp_pkg::CoordW-1:0] vertex_x,
	input  logic signed [picp_pkg::CoordW-1:0] vertex_y,
	input  logic                               last_vertex,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               inside_res,
	input  logic                               overflow,
	output int                                 errors,
	output int                                 pending
);

	typedef struct packed {
		logic in_poly;
		logic ovf;
	} verdict_t;

	// verdicts still owed by the block, oldest first
	verdict_t verdicts[$];

	// running state of the polygon being received
	logic signed [picp_pkg::CoordW-1:0] first_x = '0;
	logic signed [picp_pkg::CoordW-1:0] first_y = '0;
	logic signed [picp_pkg::CoordW-1:0] prev_x = '0;
	logic signed [picp_pkg::CoordW-1:0] prev_y = '0;
	int vert_cnt = 0;
	int neg_cnt = 0;
	bit dropped = 1'b0;

	initial begin
		errors = 0;
		pending = 0;
	end

	// sign of z for (n - p) x (q - p), exact at full width
	function automatic bit cross_is_negative(
		input logic signed [picp_pkg::CoordW-1:0] px,
		input logic signed [picp_pkg::CoordW-1:0] py,
		input logic signed [picp_pkg::CoordW-1:0] nx,
		input logic signed [picp_pkg::CoordW-1:0] ny,
		input logic signed [picp_pkg::CoordW-1:0] qx,
		input logic signed [picp_pkg::CoordW-1:0] qy
	);
		logic signed [picp_pkg::DiffW-1:0] ax, ay, bx, by;
		logic signed [picp_pkg::CrossW-1:0] z;
		ax = nx - px;
		ay = ny - py;
		bx = qx - px;
		by = qy - py;
		z = ax * by - ay * bx;
		return z[picp_pkg::CrossW-1];
	endfunction

	// fold one accepted vertex into the polygon, emit a verdict on the last one
	task automatic track_vertex(
		input logic signed [picp_pkg::CoordW-1:0] qx,
		input logic signed [picp_pkg::CoordW-1:0] qy,
		input logic signed [picp_pkg::CoordW-1:0] vx,
		input logic signed [picp_pkg::CoordW-1:0] vy,
		input logic last
	);
		verdict_t v;
		if (vert_cnt >= MAX_VERTICES) begin
			dropped = 1'b1;
		end else begin
			if (vert_cnt == 0) begin
				first_x = vx;
				first_y = vy;
			end else begin
				neg_cnt += cross_is_negative(prev_x, prev_y, vx, vy, qx, qy);
			end
			prev_x = vx;
			prev_y = vy;
			vert_cnt++;
		end
		if (last) begin
			// closing edge back to the first vertex
			neg_cnt += cross_is_negative(prev_x, prev_y, first_x, first_y, qx, qy);
			v.ovf = dropped;
			v.in_poly = !dropped && (neg_cnt == 0 || neg_cnt == vert_cnt);
			verdicts.push_back(v);
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			vert_cnt = 0;
			neg_cnt = 0;
			dropped = 1'b0;
		end
	endtask

	// compare results, then predict from accepted vertices
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdicts.size() == 0) begin
					$error("result item with no verdict pending: inside_res %0b overflow %0b",
						inside_res, overflow);
					errors++;
				end else begin
					want = verdicts.pop_front();
					if (inside_res !== want.in_poly) begin
						$error("inside_res: expected %0b, actual %0b", want.in_poly, inside_res);
						errors++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow: expected %0b, actual %0b", want.ovf, overflow);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				track_vertex(point_x, point_y, vertex_x, vertex_y, last_vertex);
			pending = verdicts.size();
		end
	end

endmodule

// File: tb/point_in_convex_polygon_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the streaming point in convex polygon test
module point_in_convex_polygon_tb;

	localparam int CoordW = picp_pkg::CoordW;
	localparam int MaxVerts = 256;
	localparam int RandItems = 1600;
	localparam real TwoPi = 6.283185307179586;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CoordW-1:0] point_x = '0;
	logic signed [CoordW-1:0] point_y = '0;
	logic signed [CoordW-1:0] vertex_x = '0;
	logic signed [CoordW-1:0] vertex_y = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic inside_res;
	logic overflow;
	int errors;
	int pending;
	bit no_gaps = 1'b0;
	int sent = 0;

	point_in_convex_polygon #(.MAX_VERTICES(MaxVerts)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .overflow(overflow)
	);

	point_in_convex_polygon_checker #(.MAX_VERTICES(MaxVerts)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .overflow(overflow),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// uniform real in [-1, 1]
	function automatic real unit();
		return ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
	endfunction

	// saturate a real coordinate into the signed 16 bit range
	function automatic logic signed [CoordW-1:0] to_coord(input real r);
		int v;
		v = $rtoi(r);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[CoordW-1:0];
	endfunction

	// random coordinate biased toward the extremes, zero and -1
	function automatic logic signed [CoordW-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return CoordW'($urandom);
		endcase
	endfunction

	// drive one vertex item after a random gap (none while no_gaps is set) and wait for it to be taken
	task automatic send_vertex(
		input logic signed [CoordW-1:0] px,
		input logic signed [CoordW-1:0] py,
		input logic signed [CoordW-1:0] vx,
		input logic signed [CoordW-1:0] vy,
		input logic last
	);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_x <= px;
		point_y <= py;
		vertex_x <= vx;
		vertex_y <= vy;
		last_vertex <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// hold off the sender until every verdict has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// one polygon: convex around a random center, or noise vertices
	task automatic send_polygon(input int n, input bit noisy);
		logic signed [CoordW-1:0] xs[320];
		logic signed [CoordW-1:0] ys[320];
		logic signed [CoordW-1:0] qx, qy;
		real cx, cy, rad, a0, stp, ang;
		int k;
		cx = 12000.0 * unit();
		cy = 12000.0 * unit();
		rad = ($urandom_range(0, 5) == 0) ? $itor($urandom_range(1, 60)) :
			$itor($urandom_range(100, 20000));
		a0 = TwoPi * unit();
		stp = TwoPi / n;
		if ($urandom_range(0, 1) == 1)
			stp = -stp;
		for (int i = 0; i < n; i++) begin
			if (noisy) begin
				xs[i] = rand_coord();
				ys[i] = rand_coord();
			end else begin
				ang = a0 + stp * (i + 0.4 * unit());
				xs[i] = to_coord(cx + rad * $cos(ang));
				ys[i] = to_coord(cy + rad * $sin(ang));
			end
		end
		// query point: well inside, nearby, on a vertex, on an edge, or anywhere
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 4))
			0: begin
				qx = to_coord(cx + 0.6 * rad * unit());
				qy = to_coord(cy + 0.6 * rad * unit());
			end
			1: begin
				qx = to_coord(cx + 2.0 * rad * unit());
				qy = to_coord(cy + 2.0 * rad * unit());
			end
			2: begin
				qx = xs[k];
				qy = ys[k];
			end
			3: begin
				qx = to_coord((real'(xs[0]) + real'(xs[n - 1])) / 2.0);
				qy = to_coord((real'(ys[0]) + real'(ys[n - 1])) / 2.0);
			end
			default: begin
				qx = rand_coord();
				qy = rand_coord();
			end
		endcase
		for (int i = 0; i < n; i++) begin
			// now and then the query point changes partway through the polygon
			if ($urandom_range(0, 11) == 0) begin
				qx = noisy ? rand_coord() : to_coord(cx + 1.5 * rad * unit());
				qy = noisy ? rand_coord() : to_coord(cy + 1.5 * rad * unit());
			end
			send_vertex(qx, qy, xs[i], ys[i], i == n - 1);
		end
	endtask

	// result side: random stall before each result item, none while no_gaps is set
	initial begin
		int stall;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single vertex, point on it, then far from it
		send_vertex(0, 0, 0, 0, 1'b1);
		send_vertex(32767, 32767, -32768, -32768, 1'b1);
		// triangle spanning the full range, point at the far corner
		send_vertex(-32768, 32767, -32768, -32768, 1'b0);
		send_vertex(-32768, 32767, 32767, -32768, 1'b0);
		send_vertex(-32768, 32767, 32767, 32767, 1'b1);
		// counterclockwise square, point at center
		send_vertex(0, 0, -8192, -8192, 1'b0);
		send_vertex(0, 0, 8192, -8192, 1'b0);
		send_vertex(0, 0, 8192, 8192, 1'b0);
		send_vertex(0, 0, -8192, 8192, 1'b1);
		// clockwise square, point inside
		send_vertex(100, -200, -8192, -8192, 1'b0);
		send_vertex(100, -200, -8192, 8192, 1'b0);
		send_vertex(100, -200, 8192, 8192, 1'b0);
		send_vertex(100, -200, 8192, -8192, 1'b1);
		// point inside a triangle
		send_vertex(8192, 0, 0, -16384, 1'b0);
		send_vertex(8192, 0, 16384, 0, 1'b0);
		send_vertex(8192, 0, 0, 16384, 1'b1);
		// point moves from inside to outside partway through
		send_vertex(0, 0, -8192, -8192, 1'b0);
		send_vertex(0, 0, 8192, -8192, 1'b0);
		send_vertex(20000, 0, 8192, 8192, 1'b0);
		send_vertex(20000, 0, -8192, 8192, 1'b1);
		// two vertices, point collinear
		send_vertex(8192, 8192, 0, 0, 1'b0);
		send_vertex(8192, 8192, 16384, 16384, 1'b1);
		drain();

		// vertex limit exactly reached, then exceeded by one
		send_polygon(MaxVerts, 1'b0);
		send_polygon(MaxVerts + 1, 1'b0);

		// random polygons, mostly convex and small
		while (sent < RandItems) begin
			if ($urandom_range(0, 149) == 0)
				n = $urandom_range(MaxVerts - 6, MaxVerts + 14);
			else
				n = $urandom_range(1, 8);
			send_polygon(n, $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 24) == 0)
				no_gaps = !no_gaps;
			if ($urandom_range(0, 39) == 0)
				drain();
		end

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
